// ===== src/gdsc_pkg.sv =====
package gdsc_pkg;

   localparam int unsigned PC_WIDTH = 4;
   localparam int unsigned ACC_WIDTH = 23;

   typedef logic [PC_WIDTH-1:0] pc_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ERR,
      COND_OP1,
      COND_YEAR_FITS,
      COND_MONTH_FITS,
      COND_YEAR_REACHED
   } cond_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_INIT,
      ACT_YSUB,
      ACT_YADD,
      ACT_MSUB,
      ACT_MADD,
      ACT_WR_DATE,
      ACT_WR_SERIAL,
      ACT_WR_ERR
   } act_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      logic     loop;
      logic     done;
      pc_type   target;
   } ctrl_word_type;

   typedef struct packed {
      logic range_err;
      logic op1;
      logic year_fits;
      logic month_fits;
      logic year_reached;
   } status_type;

   localparam pc_type STEP_INIT      = 4'd0;
   localparam pc_type STEP_DISPATCH  = 4'd1;
   localparam pc_type STEP_YEAR_SUB  = 4'd2;
   localparam pc_type STEP_MONTH_SUB = 4'd3;
   localparam pc_type STEP_WR_DATE   = 4'd4;
   localparam pc_type STEP_YEAR_ADD  = 4'd5;
   localparam pc_type STEP_MONTH_ADD = 4'd6;
   localparam pc_type STEP_WR_SERIAL = 4'd7;
   localparam pc_type STEP_WR_ERR    = 4'd8;

   localparam logic [3:0] LAST_MONTH = 4'd12;
   localparam logic [3:0] FEBRUARY   = 4'd2;

   function automatic ctrl_word_type program_rom(input pc_type pc);
      ctrl_word_type word;
      case (pc)
         STEP_INIT: begin
            word = '{act: ACT_INIT, cond: COND_ERR, loop: 1'b0, done: 1'b0,
                     target: STEP_WR_ERR};
         end
         STEP_DISPATCH: begin
            word = '{act: ACT_NONE, cond: COND_OP1, loop: 1'b0, done: 1'b0,
                     target: STEP_YEAR_ADD};
         end
         STEP_YEAR_SUB: begin
            word = '{act: ACT_YSUB, cond: COND_YEAR_FITS, loop: 1'b1, done: 1'b0,
                     target: STEP_MONTH_SUB};
         end
         STEP_MONTH_SUB: begin
            word = '{act: ACT_MSUB, cond: COND_MONTH_FITS, loop: 1'b1, done: 1'b0,
                     target: STEP_WR_DATE};
         end
         STEP_WR_DATE: begin
            word = '{act: ACT_WR_DATE, cond: COND_NEVER, loop: 1'b0, done: 1'b1,
                     target: STEP_INIT};
         end
         STEP_YEAR_ADD: begin
            word = '{act: ACT_YADD, cond: COND_YEAR_REACHED, loop: 1'b1, done: 1'b0,
                     target: STEP_MONTH_ADD};
         end
         STEP_MONTH_ADD: begin
            word = '{act: ACT_MADD, cond: COND_NEVER, loop: 1'b0, done: 1'b0,
                     target: STEP_INIT};
         end
         STEP_WR_SERIAL: begin
            word = '{act: ACT_WR_SERIAL, cond: COND_NEVER, loop: 1'b0, done: 1'b1,
                     target: STEP_INIT};
         end
         default: begin
            word = '{act: ACT_WR_ERR, cond: COND_NEVER, loop: 1'b0, done: 1'b1,
                     target: STEP_INIT};
         end
      endcase
      return word;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] days;
      case (m)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== src/gregorian_day_serial_converter.sv =====
// gregorian calendar converter: day serial (1 is 1/1/0001) to date, or date to serial
// request channel: req_valid/req_ready with req_operation, req_serial_in, req_day_in,
//   req_month_in and req_year_in; one transaction gives exactly one result
// result channel: rsp_valid/rsp_ready with day, month, year, serial and range_error
// a small program in a control rom steps one datapath: a year walk of one year per
//   cycle, then, for serial to date, a month walk of one month per cycle
// out of range operands skip both walks and go straight to the error result; the
//   longest conversions are set by the year walk loop
// one conversion is in flight at a time; req_ready is high while the sequencer is
//   idle, also while a finished result still waits in the output register
// if the receiver stalls, the final step of the next conversion waits until the
//   output register is taken
// reset (synchronous, active high) drops rsp_valid and returns the sequencer to idle
module gregorian_day_serial_converter #(
   parameter int MAX_YEAR = 9999
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [21:0] req_serial_in,
   input  logic [4:0]  req_day_in,
   input  logic [3:0]  req_month_in,
   input  logic [13:0] req_year_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_day_out,
   output logic [3:0]  rsp_month_out,
   output logic [13:0] rsp_year_out,
   output logic [21:0] rsp_serial_out,
   output logic        rsp_range_error
);

   localparam int AW = gdsc_pkg::ACC_WIDTH;
   localparam logic [AW-1:0] MAX_SERIAL =
      AW'(365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);
   localparam logic [13:0] MAX_YEAR_VAL = 14'(MAX_YEAR);

   logic        busy;
   logic        start;
   logic        out_free;
   gdsc_pkg::act_type    act;
   gdsc_pkg::status_type status;

   logic        op_ff;
   logic [21:0] serial_ff;
   logic [4:0]  day_ff;
   logic [3:0]  month_ff;
   logic [13:0] year_ff;

   logic [AW-1:0] acc_ff, acc_in;
   logic [13:0]   y_ff, y_in;
   logic [3:0]    m_ff, m_in;
   logic [6:0]    c100_ff, c100_in;
   logic [8:0]    c400_ff, c400_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    day_out_ff, day_out_in;
   logic [3:0]    month_out_ff, month_out_in;
   logic [13:0]   year_out_ff, year_out_in;
   logic [21:0]   serial_out_ff, serial_out_in;
   logic          err_out_ff, err_out_in;

   logic          leap;
   logic [AW-1:0] ylen;
   logic [AW-1:0] mlen;
   logic [AW-1:0] madd;
   logic          range_err;

   assign req_ready = !busy;
   assign start     = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign leap = ((c400_ff[1:0] == 2'd0) && (c100_ff != 7'd0)) || (c400_ff == 9'd0);
   assign ylen = leap ? AW'(366) : AW'(365);
   assign mlen = AW'(gdsc_pkg::month_length(m_ff, leap));
   assign madd = AW'(gdsc_pkg::days_before_month(month_ff))
               + AW'((month_ff > gdsc_pkg::FEBRUARY) && leap)
               + AW'(day_ff);

   always_comb begin
      if (op_ff) begin
         range_err = (year_ff == 14'd0) || (year_ff > MAX_YEAR_VAL) ||
                     (month_ff == 4'd0) || (month_ff > gdsc_pkg::LAST_MONTH);
      end else begin
         range_err = (serial_ff == 22'd0) || (AW'(serial_ff) > MAX_SERIAL);
      end
   end

   assign status.range_err    = range_err;
   assign status.op1          = op_ff;
   assign status.year_fits    = acc_ff <= ylen;
   assign status.month_fits   = (acc_ff <= mlen) || (m_ff >= gdsc_pkg::LAST_MONTH);
   assign status.year_reached = y_ff == year_ff;

   gdsc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .status   (status),
      .busy     (busy),
      .act      (act)
   );

   always_comb begin
      acc_in        = acc_ff;
      y_in          = y_ff;
      m_in          = m_ff;
      c100_in       = c100_ff;
      c400_in       = c400_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      day_out_in    = day_out_ff;
      month_out_in  = month_out_ff;
      year_out_in   = year_out_ff;
      serial_out_in = serial_out_ff;
      err_out_in    = err_out_ff;
      case (act)
         gdsc_pkg::ACT_INIT: begin
            acc_in  = op_ff ? '0 : AW'(serial_ff);
            y_in    = 14'd1;
            m_in    = 4'd1;
            c100_in = 7'd1;
            c400_in = 9'd1;
         end
         gdsc_pkg::ACT_YSUB, gdsc_pkg::ACT_YADD: begin
            acc_in  = (act == gdsc_pkg::ACT_YSUB) ? acc_ff - ylen : acc_ff + ylen;
            y_in    = y_ff + 14'd1;
            c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
            c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
         end
         gdsc_pkg::ACT_MSUB: begin
            acc_in = acc_ff - mlen;
            m_in   = m_ff + 4'd1;
         end
         gdsc_pkg::ACT_MADD: begin
            acc_in = acc_ff + madd;
         end
         gdsc_pkg::ACT_WR_DATE: begin
            rsp_valid_in  = 1'b1;
            day_out_in    = acc_ff[4:0];
            month_out_in  = m_ff;
            year_out_in   = y_ff;
            serial_out_in = '0;
            err_out_in    = 1'b0;
         end
         gdsc_pkg::ACT_WR_SERIAL: begin
            rsp_valid_in  = 1'b1;
            day_out_in    = '0;
            month_out_in  = '0;
            year_out_in   = '0;
            serial_out_in = acc_ff[AW-1] ? 22'd0 : acc_ff[21:0];
            err_out_in    = acc_ff[AW-1];
         end
         gdsc_pkg::ACT_WR_ERR: begin
            rsp_valid_in  = 1'b1;
            day_out_in    = '0;
            month_out_in  = '0;
            year_out_in   = '0;
            serial_out_in = '0;
            err_out_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff     <= req_operation;
         serial_ff <= req_serial_in;
         day_ff    <= req_day_in;
         month_ff  <= req_month_in;
         year_ff   <= req_year_in;
      end
      day_out_ff    <= day_out_in;
      month_out_ff  <= month_out_in;
      year_out_ff   <= year_out_in;
      serial_out_ff <= serial_out_in;
      err_out_ff    <= err_out_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         y_ff         <= 14'd1;
         m_ff         <= 4'd1;
         c100_ff      <= 7'd1;
         c400_ff      <= 9'd1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         y_ff         <= y_in;
         m_ff         <= m_in;
         c100_ff      <= c100_in;
         c400_ff      <= c400_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_day_out     = day_out_ff;
   assign rsp_month_out   = month_out_ff;
   assign rsp_year_out    = year_out_ff;
   assign rsp_serial_out  = serial_out_ff;
   assign rsp_range_error = err_out_ff;

endmodule

// ===== src/gdsc_sequencer.sv =====
module gdsc_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   input  gdsc_pkg::status_type status,
   output logic                 busy,
   output gdsc_pkg::act_type    act
);

   gdsc_pkg::pc_type        pc_ff, pc_in;
   logic                    busy_ff, busy_in;
   gdsc_pkg::ctrl_word_type word;
   logic                    cond_hit;

   assign word = gdsc_pkg::program_rom(pc_ff);
   assign busy = busy_ff;

   always_comb begin
      case (word.cond)
         gdsc_pkg::COND_ERR:          cond_hit = status.range_err;
         gdsc_pkg::COND_OP1:          cond_hit = status.op1;
         gdsc_pkg::COND_YEAR_FITS:    cond_hit = status.year_fits;
         gdsc_pkg::COND_MONTH_FITS:   cond_hit = status.month_fits;
         gdsc_pkg::COND_YEAR_REACHED: cond_hit = status.year_reached;
         default:                     cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      act     = gdsc_pkg::ACT_NONE;
      if (!busy_ff) begin
         if (start) begin
            pc_in   = gdsc_pkg::STEP_INIT;
            busy_in = 1'b1;
         end
      end else if (word.done) begin
         if (out_free) begin
            act     = word.act;
            busy_in = 1'b0;
         end
      end else begin
         act = cond_hit ? gdsc_pkg::ACT_NONE : word.act;
         if (cond_hit) begin
            pc_in = word.target;
         end else if (!word.loop) begin
            pc_in = pc_ff + gdsc_pkg::pc_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= gdsc_pkg::STEP_INIT;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule
